// ===== rtl/core/keyframe_linear_interpolator_defines.svh =====
// ----------------------------------------------------------------------------
// Keyframe linear interpolator assertion macros
// Shared property shapes for the concurrent checks of the interpolator.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KFLI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KFLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kfli_pkg.sv =====
// ----------------------------------------------------------------------------
// kfli_pkg
// Sizes, codes and shared types of the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kfli_pkg;

  localparam int MAX_KEYS = 64;
  localparam int KEY_AW   = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  localparam int TICK_W  = 24;
  localparam int COMP_W  = 32;
  localparam int NCOMP   = 4;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 6;
  localparam int KCNT_W  = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Component slots inside a key.
  localparam int C_X = 0;
  localparam int C_Y = 1;
  localparam int C_Z = 2;
  localparam int C_W = 3;

  localparam logic [COMP_W-1:0] Q_ONE = 32'h0001_0000;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] STAT_ACK    = 2'd0;
  localparam logic [1:0] STAT_INTERP = 2'd1;
  localparam logic [1:0] STAT_HELD   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  // Register index, taken from word address bit paddr[2].
  localparam logic REG_KEY_COUNT = 1'b0;
  localparam logic REG_ROT_MODE  = 1'b1;

  typedef logic [NCOMP-1:0][COMP_W-1:0] comp_vec_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    comp_vec_t         comp;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] num;
    logic [TICK_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [FRAC_W-1:0] t;
  } blend_req_t;

  typedef struct packed {
    logic      done;
    comp_vec_t comp;
  } blend_rsp_t;

endpackage

// ===== rtl/core/kfli_key_ram.sv =====
// ----------------------------------------------------------------------------
// kfli_key_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module kfli_key_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/kfli_div.sv =====
// ----------------------------------------------------------------------------
// kfli_div
// Restoring divider for the blend fraction: one quotient bit per cycle,
// num < den, quotient = floor((num << FRAC_W) / den).
// ----------------------------------------------------------------------------
module kfli_div (
  input  logic               clk,
  input  logic               rst_n,
  input  kfli_pkg::div_req_t req,
  output kfli_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(kfli_pkg::FRAC_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [STEP_W-1:0]           cnt_r;
  logic [kfli_pkg::TICK_W-1:0] rem_r;
  logic [kfli_pkg::TICK_W-1:0] den_r;
  logic [kfli_pkg::FRAC_W-1:0] quot_r;

  logic [kfli_pkg::TICK_W:0]   shifted;
  logic                        fits;
  logic [kfli_pkg::TICK_W-1:0] rem_nxt;

  // The remainder stays below den, so the doubled value fits in one extra bit.
  always_comb begin
    shifted = {rem_r, 1'b0};
    fits    = shifted >= {1'b0, den_r};
    if (fits) begin
      rem_nxt = kfli_pkg::TICK_W'(shifted - {1'b0, den_r});
    end else begin
      rem_nxt = kfli_pkg::TICK_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= STEP_W'(cnt_r + 1'b1);
        if (cnt_r == STEP_W'(kfli_pkg::FRAC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      den_r  <= req.den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[kfli_pkg::FRAC_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ===== rtl/core/kfli_blend.sv =====
// ----------------------------------------------------------------------------
// kfli_blend
// Serial blend unit: one shared multiplier walks the four components,
// out = b + floor((a - b) * t / 2^FRAC_W), a multiply step then an add step.
// ----------------------------------------------------------------------------
module kfli_blend (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kfli_pkg::blend_req_t req,
  input  kfli_pkg::key_t       key_b,
  input  kfli_pkg::key_t       key_a,
  output kfli_pkg::blend_rsp_t rsp
);

  localparam int KC_W   = $clog2(kfli_pkg::NCOMP);
  localparam int PROD_W = kfli_pkg::COMP_W + kfli_pkg::FRAC_W + 2;

  typedef enum logic {
    PH_MUL,
    PH_ADD
  } phase_t;

  phase_t                      phase_r;
  logic                        busy_r;
  logic                        done_r;
  logic [KC_W-1:0]             k_r;
  logic [kfli_pkg::FRAC_W-1:0] t_r;
  logic signed [PROD_W-1:0]    prod_r;
  kfli_pkg::comp_vec_t         res_r;

  logic [kfli_pkg::COMP_W-1:0] a_c;
  logic [kfli_pkg::COMP_W-1:0] b_c;
  logic signed [kfli_pkg::COMP_W:0] diff;
  logic signed [kfli_pkg::FRAC_W:0] t_s;
  logic signed [PROD_W-1:0]    prod_nxt;
  logic [kfli_pkg::COMP_W-1:0] sum_nxt;

  always_comb begin
    a_c      = key_a.comp[k_r];
    b_c      = key_b.comp[k_r];
    diff     = $signed({a_c[kfli_pkg::COMP_W-1], a_c}) -
               $signed({b_c[kfli_pkg::COMP_W-1], b_c});
    t_s      = $signed({1'b0, t_r});
    prod_nxt = diff * t_s;
    // The arithmetic shift floors, and the result lies between b and a.
    sum_nxt  = b_c + prod_r[kfli_pkg::FRAC_W +: kfli_pkg::COMP_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MUL;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        phase_r <= PH_MUL;
        k_r     <= '0;
        t_r     <= req.t;
      end else if (busy_r) begin
        case (phase_r)
          PH_MUL: begin
            prod_r  <= prod_nxt;
            phase_r <= PH_ADD;
          end
          PH_ADD: begin
            res_r[k_r] <= sum_nxt;
            phase_r    <= PH_MUL;
            k_r        <= KC_W'(k_r + 1'b1);
            if (k_r == KC_W'(kfli_pkg::NCOMP - 1)) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            phase_r <= PH_MUL;
          end
        endcase
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.comp = res_r;

endmodule

// ===== rtl/core/keyframe_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Key table in one synchronous RAM, linear bracket scan, iterative fraction
// divider and a serial multiply-add blend.
// ----------------------------------------------------------------------------
// The block takes one request at a time. A key write passes from acceptance
// through ST_DONE to the output register. A query reads the key RAM one slot
// per cycle from slot 0 until it meets the first key whose tick is above the
// query tick or reaches the last key (up to key_count, at most 64 keys); an
// endpoint hit then finishes through ST_DONE, and an empty table skips the
// scan and goes straight to ST_DONE. A query that lands between two keys then
// runs the bit-serial fraction divider and the blend (one shared multiplier,
// a multiply step and an add step per component) before ST_DONE.
// The single read port of the key RAM and the one-bit-per-cycle divider bound
// the query time. A finished result waits in an output register, and the next
// request is accepted while it waits. The key table has no reset: a query
// must only touch slots that have been written. Configuration (key_count at
// byte address 0, rotation_mode at byte address 4) may only be written while
// no request is in flight.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_defines.svh"

module keyframe_linear_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [kfli_pkg::PADDR_W-1:0] paddr,
  input  logic        [kfli_pkg::PDATA_W-1:0] pwdata,
  output logic        [kfli_pkg::PDATA_W-1:0] prdata,
  output logic                                pready,
  // Request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic        [kfli_pkg::IDX_W-1:0]   in_key_index,
  input  logic        [kfli_pkg::TICK_W-1:0]  in_tick,
  input  logic signed [kfli_pkg::COMP_W-1:0]  in_comp_x,
  input  logic signed [kfli_pkg::COMP_W-1:0]  in_comp_y,
  input  logic signed [kfli_pkg::COMP_W-1:0]  in_comp_z,
  input  logic signed [kfli_pkg::COMP_W-1:0]  in_comp_w,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [kfli_pkg::COMP_W-1:0]  out_x,
  output logic signed [kfli_pkg::COMP_W-1:0]  out_y,
  output logic signed [kfli_pkg::COMP_W-1:0]  out_z,
  output logic signed [kfli_pkg::COMP_W-1:0]  out_w,
  output logic        [1:0]                   out_status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_BLEND,
    ST_DONE
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers. Only word address bit 2 selects the register.
  // --------------------------------------------------------------------------
  logic [kfli_pkg::KCNT_W-1:0] key_count_r;
  logic                        rotation_mode_r;
  logic                        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r     <= '0;
      rotation_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[2])
        kfli_pkg::REG_KEY_COUNT: key_count_r     <= pwdata[kfli_pkg::KCNT_W-1:0];
        kfli_pkg::REG_ROT_MODE:  rotation_mode_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      kfli_pkg::REG_KEY_COUNT: prdata = kfli_pkg::PDATA_W'(key_count_r);
      kfli_pkg::REG_ROT_MODE:  prdata = kfli_pkg::PDATA_W'(rotation_mode_r);
      default:                 prdata = '0;
    endcase
  end

  // A key count above the table depth is treated as a full table.
  logic [kfli_pkg::CNT_W-1:0] n_keys;

  always_comb begin
    if (32'(key_count_r) > kfli_pkg::MAX_KEYS) begin
      n_keys = kfli_pkg::CNT_W'(kfli_pkg::MAX_KEYS);
    end else begin
      n_keys = kfli_pkg::CNT_W'(key_count_r);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  state_t                      state_r;
  logic [kfli_pkg::TICK_W-1:0] q_tick_r;
  logic [kfli_pkg::KEY_AW-1:0] scan_i_r;
  kfli_pkg::key_t              prev_r;
  kfli_pkg::key_t              key_a_r;
  kfli_pkg::key_t              key_b_r;
  kfli_pkg::comp_vec_t         res_comp_r;
  logic [1:0]                  res_status_r;
  kfli_pkg::comp_vec_t         out_comp_r;
  logic [1:0]                  out_status_r;
  logic                        out_valid_r;

  logic                        in_accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Key RAM. Writes land at the accept edge of a key write. During a scan the
  // read address runs one slot ahead of the slot being compared, so one key
  // is examined per cycle; in idle it sits at slot 0, ready for a query.
  // --------------------------------------------------------------------------
  logic                        ram_we;
  logic [kfli_pkg::KEY_AW-1:0] ram_wr_addr;
  logic [kfli_pkg::KEY_AW-1:0] ram_rd_addr;
  kfli_pkg::key_t              wr_key;
  logic [kfli_pkg::KEY_W-1:0]  rd_word;
  kfli_pkg::key_t              rd_key;

  always_comb begin
    wr_key.tick            = in_tick;
    wr_key.comp[kfli_pkg::C_X] = in_comp_x;
    wr_key.comp[kfli_pkg::C_Y] = in_comp_y;
    wr_key.comp[kfli_pkg::C_Z] = in_comp_z;
    wr_key.comp[kfli_pkg::C_W] = in_comp_w;
  end

  assign ram_we      = in_accept && (in_func == kfli_pkg::FUNC_WRITE) &&
                       (32'(in_key_index) < kfli_pkg::MAX_KEYS);
  assign ram_wr_addr = kfli_pkg::KEY_AW'(in_key_index);
  assign ram_rd_addr = (state_r == ST_SCAN) ?
                       kfli_pkg::KEY_AW'(scan_i_r + 1'b1) : '0;
  assign rd_key      = rd_word;

  kfli_key_ram #(
    .DATA_W (kfli_pkg::KEY_W),
    .DEPTH  (kfli_pkg::MAX_KEYS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (wr_key),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_word)
  );

  // --------------------------------------------------------------------------
  // Scan decisions. The slot under comparison is scan_i_r; its data is on the
  // RAM output. The first key above the query tick ends the scan. If that is
  // slot 0 the first key is held; if no key is above it, the last is held.
  // Otherwise the previous slot and this one bracket the query tick.
  // --------------------------------------------------------------------------
  logic key_above;
  logic scan_last;
  logic found_mid;

  assign key_above = (state_r == ST_SCAN) && (rd_key.tick > q_tick_r);
  assign scan_last = (kfli_pkg::CNT_W'(scan_i_r) == kfli_pkg::CNT_W'(n_keys - 1'b1));
  assign found_mid = key_above && (scan_i_r != '0);

  // --------------------------------------------------------------------------
  // Fraction divider and blend unit
  // --------------------------------------------------------------------------
  kfli_pkg::div_req_t   div_req;
  kfli_pkg::div_rsp_t   div_rsp;
  kfli_pkg::blend_req_t blend_req;
  kfli_pkg::blend_rsp_t blend_rsp;

  // Bracketing keys satisfy tick_b <= query < tick_a, so num < den and den > 0.
  assign div_req.start = found_mid;
  assign div_req.num   = q_tick_r - prev_r.tick;
  assign div_req.den   = rd_key.tick - prev_r.tick;

  kfli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign blend_req.start = (state_r == ST_DIV) && div_rsp.done;
  assign blend_req.t     = div_rsp.quot;

  kfli_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (blend_req),
    .key_b (key_b_r),
    .key_a (key_a_r),
    .rsp   (blend_rsp)
  );

  // --------------------------------------------------------------------------
  // Result shaping. An empty table answers with the identity quaternion; in
  // vector mode w is forced to zero when the result moves to the output
  // register. The output register loads when the finished result finds it
  // empty or being drained in the same cycle.
  // --------------------------------------------------------------------------
  kfli_pkg::comp_vec_t empty_comp;
  kfli_pkg::comp_vec_t out_comp_nxt;
  logic                out_load;

  always_comb begin
    empty_comp                 = '0;
    empty_comp[kfli_pkg::C_W]  = kfli_pkg::Q_ONE;
    out_comp_nxt               = res_comp_r;
    if (!rotation_mode_r) begin
      out_comp_nxt[kfli_pkg::C_W] = '0;
    end
  end

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // --------------------------------------------------------------------------
  // Sequencer and output register. Write results carry zeros.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            q_tick_r <= in_tick;
            scan_i_r <= '0;
            if (in_func == kfli_pkg::FUNC_WRITE) begin
              res_comp_r   <= '0;
              res_status_r <= kfli_pkg::STAT_ACK;
              state_r      <= ST_DONE;
            end else if (n_keys == '0) begin
              res_comp_r   <= empty_comp;
              res_status_r <= kfli_pkg::STAT_EMPTY;
              state_r      <= ST_DONE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          prev_r <= rd_key;
          if (found_mid) begin
            key_b_r <= prev_r;
            key_a_r <= rd_key;
            state_r <= ST_DIV;
          end else if (key_above || scan_last) begin
            res_comp_r   <= rd_key.comp;
            res_status_r <= kfli_pkg::STAT_HELD;
            state_r      <= ST_DONE;
          end else begin
            scan_i_r <= kfli_pkg::KEY_AW'(scan_i_r + 1'b1);
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state_r <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (blend_rsp.done) begin
            res_comp_r   <= blend_rsp.comp;
            res_status_r <= kfli_pkg::STAT_INTERP;
            state_r      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_comp_r   <= out_comp_nxt;
            out_status_r <= res_status_r;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_x      = out_comp_r[kfli_pkg::C_X];
  assign out_y      = out_comp_r[kfli_pkg::C_Y];
  assign out_z      = out_comp_r[kfli_pkg::C_Z];
  assign out_w      = out_comp_r[kfli_pkg::C_W];
  assign out_status = out_status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `KFLI_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_accept, !in_ready, "request taken while busy")
  `KFLI_ASSERT_SAME(a_div_done, clk, rst_n, div_rsp.done, state_r == ST_DIV, "late divider done")
  `KFLI_ASSERT_SAME(a_blend_done, clk, rst_n, blend_rsp.done, state_r == ST_BLEND, "late blend")
  `KFLI_ASSERT_NEXT(a_done_loads, clk, rst_n, out_load, out_valid_r && in_ready, "load missed")

endmodule
